FILE: rtl/core/cetrb_pkg.sv
// ----------------------------------------------------------------------------
// cetrb_pkg
// Shared types and constants for the channel end token receive buffer.
// ----------------------------------------------------------------------------
package cetrb_pkg;

  localparam int BUFFER_DEPTH = 8;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int WORD_TOKENS  = 4;
  localparam int FREE_W       = 4;
  localparam int TOKEN_W      = 9;  // bit 8 marks a control token
  localparam int CFG_INDEX_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_END_TOKEN   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_TOKEN = 8'd1;

  localparam logic [7:0] END_TOKEN_RESET   = 8'd1;
  localparam logic [7:0] PAUSE_TOKEN_RESET = 8'd2;

  typedef enum logic [3:0] {
    ACT_RX_DATA    = 4'd0,
    ACT_RX_CTRL    = 4'd1,
    ACT_RX_WORD    = 4'd2,
    ACT_IN_WORD    = 4'd3,
    ACT_IN_TOKEN   = 4'd4,
    ACT_IN_CTRL    = 4'd5,
    ACT_CHECK_CTRL = 4'd6,
    ACT_TEST_CTRL  = 4'd7,
    ACT_TEST_WORD  = 4'd8
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLOCK   = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  token_value;
    logic [31:0] word_value;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_data;
    logic        front_is_control;
    logic [2:0]  ct_position;
    logic        wake_reader;
    logic [FREE_W-1:0] free_space;
  } result_t;

endpackage

FILE: rtl/core/cetrb_core.sv
// ----------------------------------------------------------------------------
// cetrb_core
// Token queue with the head kept at entry 0, reader wait state, and the
// combinational decode of one registered item into its result.
// ----------------------------------------------------------------------------
module cetrb_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  cetrb_pkg::item_t    item,
  input  logic [7:0]          pause_code,
  output cetrb_pkg::result_t  res
);

  localparam int DEPTH = cetrb_pkg::BUFFER_DEPTH;
  localparam int CNT_W = cetrb_pkg::CNT_W;
  localparam int IDX_W = cetrb_pkg::IDX_W;
  localparam int TW    = cetrb_pkg::TOKEN_W;
  localparam int WT    = cetrb_pkg::WORD_TOKENS;

  logic [TW-1:0]    q      [DEPTH];
  logic [TW-1:0]    q_next [DEPTH];
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             waiting, waiting_next;
  logic             wait_word, wait_word_next;

  cetrb_pkg::act_t  act;
  logic [CNT_W-1:0] free_now;
  logic [2:0]       ct_pos;
  logic             head_ct;
  logic             pushed;

  assign act      = cetrb_pkg::act_t'(item.action);
  assign free_now = CNT_W'(DEPTH) - cnt;
  assign head_ct  = q[0][8];

  // first control token among the first four held
  always_comb begin
    ct_pos = 3'd0;
    for (int i = WT - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt) && q[i][8]) ct_pos = 3'(i + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) q_next[i] = q[i];
    cnt_next       = cnt;
    waiting_next   = waiting;
    wait_word_next = wait_word;
    pushed         = 1'b0;
    res            = '0;
    res.status     = cetrb_pkg::ST_OK;

    case (act)
      cetrb_pkg::ACT_RX_DATA, cetrb_pkg::ACT_RX_CTRL: begin
        if (cnt == CNT_W'(DEPTH)) begin
          res.status = cetrb_pkg::ST_FULL;
        end else if (!(act == cetrb_pkg::ACT_RX_CTRL && item.token_value == pause_code)) begin
          q_next[cnt[IDX_W-1:0]] = {(act == cetrb_pkg::ACT_RX_CTRL), item.token_value};
          cnt_next = cnt + CNT_W'(1);
          pushed   = 1'b1;
        end
      end
      cetrb_pkg::ACT_RX_WORD: begin
        if (free_now < CNT_W'(WT)) begin
          res.status = cetrb_pkg::ST_FULL;
        end else begin
          for (int k = 0; k < WT; k++) begin
            q_next[IDX_W'(cnt + CNT_W'(k))] = {1'b0, item.word_value[8*(WT-1-k) +: 8]};
          end
          cnt_next = cnt + CNT_W'(WT);
          pushed   = 1'b1;
        end
      end
      cetrb_pkg::ACT_IN_WORD, cetrb_pkg::ACT_TEST_WORD: begin
        if (ct_pos == 3'd0 && cnt < CNT_W'(WT)) begin
          res.status     = cetrb_pkg::ST_BLOCK;
          waiting_next   = 1'b1;
          wait_word_next = 1'b1;
        end else if (act == cetrb_pkg::ACT_TEST_WORD) begin
          res.ct_position = ct_pos;
        end else if (ct_pos != 3'd0) begin
          res.status = cetrb_pkg::ST_ILLEGAL;
        end else begin
          res.read_data = {q[0][7:0], q[1][7:0], q[2][7:0], q[3][7:0]};
          for (int i = 0; i < DEPTH; i++) begin
            if (i + WT < DEPTH) q_next[i] = q[(i + WT) % DEPTH];
          end
          cnt_next = cnt - CNT_W'(WT);
        end
      end
      cetrb_pkg::ACT_IN_TOKEN, cetrb_pkg::ACT_IN_CTRL,
      cetrb_pkg::ACT_CHECK_CTRL, cetrb_pkg::ACT_TEST_CTRL: begin
        if (cnt == '0) begin
          res.status     = cetrb_pkg::ST_BLOCK;
          waiting_next   = 1'b1;
          wait_word_next = 1'b0;
        end else if (act == cetrb_pkg::ACT_TEST_CTRL) begin
          res.front_is_control = head_ct;
        end else if ((act == cetrb_pkg::ACT_IN_TOKEN && head_ct) ||
                     (act != cetrb_pkg::ACT_IN_TOKEN && !head_ct) ||
                     (act == cetrb_pkg::ACT_CHECK_CTRL && q[0][7:0] != item.token_value)) begin
          res.status = cetrb_pkg::ST_ILLEGAL;
        end else begin
          if (act != cetrb_pkg::ACT_CHECK_CTRL) res.read_data = {24'd0, q[0][7:0]};
          for (int i = 0; i < DEPTH; i++) begin
            if (i + 1 < DEPTH) q_next[i] = q[(i + 1) % DEPTH];
          end
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (pushed && waiting && (!wait_word || cnt_next >= CNT_W'(WT))) begin
      waiting_next    = 1'b0;
      res.wake_reader = 1'b1;
    end

    res.free_space = cetrb_pkg::FREE_W'(CNT_W'(DEPTH) - cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      waiting   <= 1'b0;
      wait_word <= 1'b0;
    end else if (step) begin
      cnt       <= cnt_next;
      waiting   <= waiting_next;
      wait_word <= wait_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < DEPTH; i++) q[i] <= q_next[i];
    end
  end

endmodule

FILE: rtl/core/channel_end_token_receive_buffer.sv
// ----------------------------------------------------------------------------
// channel_end_token_receive_buffer
// Receive-side token FIFO of a channel end with data, control and word
// access, would-block tracking and reader wake-up.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result channel is not stalled.
// Path: input register, one decode, result register.
// Reset (rst, synchronous): empty queue, no waiting reader, pause code 2,
// both stages empty. Token storage is not cleared.
// ----------------------------------------------------------------------------
module channel_end_token_receive_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // token_value[7:0], word_value[39:8]
  input  logic [3:0]  s_tuser,   // action[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_data[31:0], front_is_control[32],
                                 // ct_position[35:33], wake_reader[36],
                                 // free_space[40:37], zero[47:41]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cetrb_pkg::item_t   item;
  cetrb_pkg::result_t res;
  logic               in_full;
  logic               adv;
  logic [7:0]         pause_code;

  assign adv       = in_full && (!m_tvalid || m_tready);
  assign s_tready  = !in_full || adv;
  assign cfg_ready = 1'b1;

  // end token code needs no register: end tokens are stored as any control token
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      m_tvalid   <= 1'b0;
      pause_code <= cetrb_pkg::PAUSE_TOKEN_RESET;
    end else begin
      if (s_tvalid && s_tready) in_full <= 1'b1;
      else if (adv)             in_full <= 1'b0;
      if (adv)           m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cfg_valid && cfg_index == cetrb_pkg::CFG_PAUSE_TOKEN) pause_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action      <= s_tuser;
      item.token_value <= s_tdata[7:0];
      item.word_value  <= s_tdata[39:8];
    end
    if (adv) begin
      m_tuser <= res.status;
      m_tdata <= {7'd0, res.free_space, res.wake_reader, res.ct_position,
                  res.front_is_control, res.read_data};
    end
  end

  cetrb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .item       (item),
    .pause_code (pause_code),
    .res        (res)
  );

endmodule

FILE: rtl/core/cetrb_check.sv
// ----------------------------------------------------------------------------
// cetrb_check
// Port-level checks on the result channel of the token receive buffer.
// ----------------------------------------------------------------------------
module cetrb_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[40:37] <= 4'd8)
    else $error("free space above buffer depth");

  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cetrb_pkg::ST_FULL |-> m_tdata[31:0] == 32'd0 && !m_tdata[36])
    else $error("rejected push returned data or woke the reader");

  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35:33] != 3'd0 |-> m_tuser == cetrb_pkg::ST_OK &&
      m_tdata[35:33] <= 3'd4 && m_tdata[31:0] == 32'd0)
    else $error("control position with bad status or range");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind channel_end_token_receive_buffer cetrb_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
